>>> src/dtt_pkg.sv
// Shared types and constants for the two-way ranging time-of-flight block.
`timescale 1ns / 1ps

package dtt_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int STAMP_BITS    = 40;
    localparam int TIME_W        = 40;
    localparam int OUT_W         = 48;
    localparam int DEN_W         = STAMP_BITS + 2;
    localparam int PROD_W        = 2 * STAMP_BITS;
    localparam int NUM_W         = PROD_W + FRACTION_BITS;
    localparam int HI_W          = NUM_W - OUT_W;
    localparam int CMP_W         = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int HALF_LO       = (STAMP_BITS + 1) / 2;
    localparam int HALF_HI       = STAMP_BITS - HALF_LO;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_RANGING = 2'd1,
        ST_ZERO_DEN    = 2'd2,
        ST_SATURATED   = 2'd3
    } status_t;

    typedef struct packed {
        logic [STAMP_BITS-1:0] big_r1;
        logic [STAMP_BITS-1:0] small_r1;
        logic [STAMP_BITS-1:0] big_r2;
        logic [STAMP_BITS-1:0] small_r2;
        logic [DEN_W-1:0]      den;
        status_t               status;
    } work_t;

endpackage

>>> src/ds_twr_time_of_flight.sv
// Throughput: one exchange per cycle when the output is not stalled; the 48-stage restoring
// divider, one quotient bit per stage, sets the latency, and a 4-entry queue decouples
// classification from it.
// Reset (rst_n, asynchronous, active low) clears all valid flags, queue pointers and
// counts; no item is held after reset.
`timescale 1ns / 1ps

module ds_twr_time_of_flight (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [dtt_pkg::TIME_W-1:0] first_request_time,
    input  logic [dtt_pkg::TIME_W-1:0] first_response_time,
    input  logic [dtt_pkg::TIME_W-1:0] first_reception_time,
    input  logic [dtt_pkg::TIME_W-1:0] first_transmission_time,
    input  logic [dtt_pkg::TIME_W-1:0] final_request_time,
    input  logic [dtt_pkg::TIME_W-1:0] final_response_time,
    input  logic [dtt_pkg::TIME_W-1:0] final_reception_time,
    input  logic [dtt_pkg::TIME_W-1:0] final_transmission_time,
    input  logic                       code_is_ranging,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [dtt_pkg::OUT_W-1:0] flight_time,
    output logic [1:0]                 result_status
);

    logic           push;
    logic           full;
    logic           pop;
    logic           empty;
    dtt_pkg::work_t push_data;
    dtt_pkg::work_t pop_data;
    logic [dtt_pkg::OUT_W-1:0] ft;

    assign flight_time = ft;

    dtt_front u_front (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .in_valid                (in_valid),
        .in_ready                (in_ready),
        .first_request_time      (first_request_time),
        .first_response_time     (first_response_time),
        .first_reception_time    (first_reception_time),
        .first_transmission_time (first_transmission_time),
        .final_request_time      (final_request_time),
        .final_response_time     (final_response_time),
        .final_reception_time    (final_reception_time),
        .final_transmission_time (final_transmission_time),
        .code_is_ranging         (code_is_ranging),
        .push                    (push),
        .push_data               (push_data),
        .full                    (full)
    );

    dtt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .pop_data  (pop_data)
    );

    dtt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .pop           (pop),
        .pop_data      (pop_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .flight_time   (ft),
        .result_status (result_status)
    );

endmodule

>>> src/dtt_front.sv
// Front stage: forms the four intervals and the denominator, classifies the item.
`timescale 1ns / 1ps

module dtt_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [dtt_pkg::TIME_W-1:0] first_request_time,
    input  logic [dtt_pkg::TIME_W-1:0] first_response_time,
    input  logic [dtt_pkg::TIME_W-1:0] first_reception_time,
    input  logic [dtt_pkg::TIME_W-1:0] first_transmission_time,
    input  logic [dtt_pkg::TIME_W-1:0] final_request_time,
    input  logic [dtt_pkg::TIME_W-1:0] final_response_time,
    input  logic [dtt_pkg::TIME_W-1:0] final_reception_time,
    input  logic [dtt_pkg::TIME_W-1:0] final_transmission_time,
    input  logic                       code_is_ranging,
    output logic                       push,
    output dtt_pkg::work_t             push_data,
    input  logic                       full
);

    logic           valid_reg;
    dtt_pkg::work_t data_reg;
    dtt_pkg::work_t data_next;
    logic           take;

    assign push     = valid_reg && !full;
    assign in_ready = !valid_reg || !full;
    assign take     = in_valid && in_ready;
    assign push_data = data_reg;

    always_comb
    begin
        data_next.big_r1   = first_response_time[dtt_pkg::STAMP_BITS-1:0]
                           - first_request_time[dtt_pkg::STAMP_BITS-1:0];
        data_next.small_r1 = first_transmission_time[dtt_pkg::STAMP_BITS-1:0]
                           - first_reception_time[dtt_pkg::STAMP_BITS-1:0];
        data_next.big_r2   = final_response_time[dtt_pkg::STAMP_BITS-1:0]
                           - final_request_time[dtt_pkg::STAMP_BITS-1:0];
        data_next.small_r2 = final_transmission_time[dtt_pkg::STAMP_BITS-1:0]
                           - final_reception_time[dtt_pkg::STAMP_BITS-1:0];
        data_next.den = dtt_pkg::DEN_W'(data_next.big_r1) + dtt_pkg::DEN_W'(data_next.small_r1)
                      + dtt_pkg::DEN_W'(data_next.big_r2) + dtt_pkg::DEN_W'(data_next.small_r2);
        if (!code_is_ranging)
        begin
            data_next.status = dtt_pkg::ST_NOT_RANGING;
        end
        else if (data_next.den == '0)
        begin
            data_next.status = dtt_pkg::ST_ZERO_DEN;
        end
        else
        begin
            data_next.status = dtt_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/dtt_fifo.sv
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps

module dtt_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dtt_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output dtt_pkg::work_t pop_data
);

    dtt_pkg::work_t                mem [dtt_pkg::FIFO_DEPTH];
    logic [dtt_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [dtt_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [dtt_pkg::FIFO_AW:0]     count_reg;

    assign full     = (count_reg == (dtt_pkg::FIFO_AW+1)'(dtt_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/dtt_back.sv
// Back part: split products, numerator, overflow check and one-bit-per-stage divider.
`timescale 1ns / 1ps

module dtt_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      empty,
    output logic                      pop,
    input  dtt_pkg::work_t            pop_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [dtt_pkg::OUT_W-1:0] flight_time,
    output logic [1:0]                result_status
);

    localparam int LL_W = 2 * dtt_pkg::HALF_LO;
    localparam int LH_W = dtt_pkg::HALF_LO + dtt_pkg::HALF_HI;
    localparam int HH_W = 2 * dtt_pkg::HALF_HI;

    typedef struct packed {
        logic [LL_W-1:0] ll;
        logic [LH_W-1:0] lh;
        logic [LH_W-1:0] hl;
        logic [HH_W-1:0] hh;
    } part_t;

    typedef struct packed {
        logic [dtt_pkg::DEN_W-1:0] rem;
        logic [dtt_pkg::OUT_W-1:0] numlo;
        logic [dtt_pkg::OUT_W-1:0] quo;
        logic [dtt_pkg::DEN_W-1:0] den;
        logic                      neg;
        logic                      ovf;
        dtt_pkg::status_t          status;
    } div_t;

    function automatic part_t split_mul(input logic [dtt_pkg::STAMP_BITS-1:0] a,
                                        input logic [dtt_pkg::STAMP_BITS-1:0] b);
        part_t p;
        p.ll = a[dtt_pkg::HALF_LO-1:0] * b[dtt_pkg::HALF_LO-1:0];
        p.lh = a[dtt_pkg::HALF_LO-1:0] * b[dtt_pkg::STAMP_BITS-1:dtt_pkg::HALF_LO];
        p.hl = a[dtt_pkg::STAMP_BITS-1:dtt_pkg::HALF_LO] * b[dtt_pkg::HALF_LO-1:0];
        p.hh = a[dtt_pkg::STAMP_BITS-1:dtt_pkg::HALF_LO]
             * b[dtt_pkg::STAMP_BITS-1:dtt_pkg::HALF_LO];
        return p;
    endfunction

    function automatic logic [dtt_pkg::PROD_W-1:0] join_parts(input part_t p);
        logic [dtt_pkg::PROD_W-1:0] mid;
        mid = dtt_pkg::PROD_W'(p.lh) + dtt_pkg::PROD_W'(p.hl);
        return dtt_pkg::PROD_W'(p.ll) + (mid << dtt_pkg::HALF_LO)
             + (dtt_pkg::PROD_W'(p.hh) << (2 * dtt_pkg::HALF_LO));
    endfunction

    function automatic div_t div_step(input div_t s);
        div_t                      r;
        logic [dtt_pkg::DEN_W:0]   t;
        logic [dtt_pkg::DEN_W:0]   d;
        r = s;
        t = {s.rem, s.numlo[dtt_pkg::OUT_W-1]};
        d = {1'b0, s.den};
        r.numlo = s.numlo << 1;
        if (t >= d)
        begin
            t     = t - d;
            r.quo = {s.quo[dtt_pkg::OUT_W-2:0], 1'b1};
        end
        else
        begin
            r.quo = {s.quo[dtt_pkg::OUT_W-2:0], 1'b0};
        end
        r.rem = t[dtt_pkg::DEN_W-1:0];
        return r;
    endfunction

    logic en;

    // stage A: partial products
    logic                      a_valid_reg;
    part_t                     a_pa_reg;
    part_t                     a_pb_reg;
    logic [dtt_pkg::DEN_W-1:0] a_den_reg;
    dtt_pkg::status_t          a_status_reg;

    // stage B: full products
    logic                       b_valid_reg;
    logic [dtt_pkg::PROD_W-1:0] b_pa_reg;
    logic [dtt_pkg::PROD_W-1:0] b_pb_reg;
    logic [dtt_pkg::DEN_W-1:0]  b_den_reg;
    dtt_pkg::status_t           b_status_reg;

    // stage C: scaled numerator magnitude and sign
    logic                      c_valid_reg;
    logic [dtt_pkg::NUM_W-1:0] c_num_reg;
    logic                      c_neg_reg;
    logic [dtt_pkg::DEN_W-1:0] c_den_reg;
    dtt_pkg::status_t          c_status_reg;

    logic [dtt_pkg::PROD_W-1:0] c_mag_next;
    div_t                       d_next;
    logic [dtt_pkg::CMP_W-1:0]  hi_ext;
    logic [dtt_pkg::CMP_W-1:0]  den_ext;

    logic dv_reg [dtt_pkg::OUT_W+1];
    div_t dd_reg [dtt_pkg::OUT_W+1];

    logic                      out_valid_reg;
    logic [dtt_pkg::OUT_W-1:0] flight_time_reg;
    dtt_pkg::status_t          status_reg;
    logic [dtt_pkg::OUT_W-1:0] ft_next;
    dtt_pkg::status_t          status_next;
    div_t                      last;
    logic                      sat;
    logic [dtt_pkg::OUT_W-1:0] mag;

    assign en            = !out_valid_reg || out_ready;
    assign pop           = en && !empty;
    assign out_valid     = out_valid_reg;
    assign flight_time   = flight_time_reg;
    assign result_status = status_reg;

    always_comb
    begin
        c_mag_next = (b_pa_reg >= b_pb_reg) ? (b_pa_reg - b_pb_reg) : (b_pb_reg - b_pa_reg);
    end

    // quotient fits in OUT_W bits only if the numerator's upper part is below the divisor
    always_comb
    begin
        hi_ext   = dtt_pkg::CMP_W'(c_num_reg[dtt_pkg::NUM_W-1:dtt_pkg::OUT_W]);
        den_ext  = dtt_pkg::CMP_W'(c_den_reg);
        d_next.ovf    = (hi_ext >= den_ext);
        d_next.rem    = d_next.ovf ? '0 : hi_ext[dtt_pkg::DEN_W-1:0];
        d_next.numlo  = c_num_reg[dtt_pkg::OUT_W-1:0];
        d_next.quo    = '0;
        d_next.den    = c_den_reg;
        d_next.neg    = c_neg_reg;
        d_next.status = c_status_reg;
    end

    always_comb
    begin
        last = dd_reg[dtt_pkg::OUT_W];
        mag  = last.quo;
        if (last.neg)
        begin
            sat = last.ovf || (last.quo[dtt_pkg::OUT_W-1] && (|last.quo[dtt_pkg::OUT_W-2:0]));
            if (sat)
            begin
                mag = {1'b1, {(dtt_pkg::OUT_W-1){1'b0}}};
            end
        end
        else
        begin
            sat = last.ovf || last.quo[dtt_pkg::OUT_W-1];
            if (sat)
            begin
                mag = {1'b0, {(dtt_pkg::OUT_W-1){1'b1}}};
            end
        end
        if (last.status != dtt_pkg::ST_OK)
        begin
            ft_next     = '0;
            status_next = last.status;
        end
        else
        begin
            ft_next     = last.neg ? (~mag + 1'b1) : mag;
            status_next = sat ? dtt_pkg::ST_SATURATED : dtt_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= dtt_pkg::OUT_W; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            a_valid_reg <= !empty;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            dv_reg[0]   <= c_valid_reg;
            for (int i = 0; i < dtt_pkg::OUT_W; i++)
            begin
                dv_reg[i+1] <= dv_reg[i];
            end
            out_valid_reg <= dv_reg[dtt_pkg::OUT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pa_reg     <= split_mul(pop_data.big_r1, pop_data.big_r2);
            a_pb_reg     <= split_mul(pop_data.small_r1, pop_data.small_r2);
            a_den_reg    <= pop_data.den;
            a_status_reg <= pop_data.status;

            b_pa_reg     <= join_parts(a_pa_reg);
            b_pb_reg     <= join_parts(a_pb_reg);
            b_den_reg    <= a_den_reg;
            b_status_reg <= a_status_reg;

            c_num_reg    <= dtt_pkg::NUM_W'(c_mag_next) << dtt_pkg::FRACTION_BITS;
            c_neg_reg    <= (b_pa_reg < b_pb_reg);
            c_den_reg    <= b_den_reg;
            c_status_reg <= b_status_reg;

            dd_reg[0] <= d_next;
            for (int i = 0; i < dtt_pkg::OUT_W; i++)
            begin
                dd_reg[i+1] <= div_step(dd_reg[i]);
            end

            flight_time_reg <= ft_next;
            status_reg      <= status_next;
        end
    end

endmodule

>>> tb/ds_twr_time_of_flight_test.sv
// Testbench for the two-way ranging time-of-flight block: directed table, then random exchanges.
`timescale 1ns / 1ps

module ds_twr_time_of_flight_test;
    import dtt_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int N_RANDOM    = 600;

    typedef struct {
        logic [TIME_W-1:0]   stamp [8];
        logic                ranging;
        logic                known;   // expected result typed in the table
        logic signed [OUT_W-1:0] tof;
        status_t             status;
    } exchange_t;

    typedef struct {
        logic signed [OUT_W-1:0] tof;
        status_t                 status;
    } ranging_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [TIME_W-1:0] first_request_time;
    logic [TIME_W-1:0] first_response_time;
    logic [TIME_W-1:0] first_reception_time;
    logic [TIME_W-1:0] first_transmission_time;
    logic [TIME_W-1:0] final_request_time;
    logic [TIME_W-1:0] final_response_time;
    logic [TIME_W-1:0] final_reception_time;
    logic [TIME_W-1:0] final_transmission_time;
    logic code_is_ranging;
    logic out_valid;
    logic out_ready;
    logic signed [OUT_W-1:0] flight_time;
    logic [1:0] result_status;

    ranging_result_t pending_results [$];
    exchange_t       directed [$];
    int  error_count;
    int  idle_cycles;
    bit  stim_done;
    bit  long_hold;

    ds_twr_time_of_flight DUT (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .in_valid                (in_valid),
        .in_ready                (in_ready),
        .first_request_time      (first_request_time),
        .first_response_time     (first_response_time),
        .first_reception_time    (first_reception_time),
        .first_transmission_time (first_transmission_time),
        .final_request_time      (final_request_time),
        .final_response_time     (final_response_time),
        .final_reception_time    (final_reception_time),
        .final_transmission_time (final_transmission_time),
        .code_is_ranging         (code_is_ranging),
        .out_valid               (out_valid),
        .out_ready               (out_ready),
        .flight_time             (flight_time),
        .result_status           (result_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Exact time of flight: (R1*R2 - r1*r2) * 2^F / (R1+R2+r1+r2), truncated and saturated.
    function automatic ranging_result_t flight_of(exchange_t x);
        logic [STAMP_BITS-1:0] big1, sm1, big2, sm2;
        logic [DEN_W-1:0]      den;
        logic [PROD_W-1:0]     pa, pb, diff;
        logic [NUM_W-1:0]      quo;
        logic [OUT_W-1:0]      lim;
        logic                  neg;
        ranging_result_t       r;
        big1 = x.stamp[1][STAMP_BITS-1:0] - x.stamp[0][STAMP_BITS-1:0];
        sm1  = x.stamp[3][STAMP_BITS-1:0] - x.stamp[2][STAMP_BITS-1:0];
        big2 = x.stamp[5][STAMP_BITS-1:0] - x.stamp[4][STAMP_BITS-1:0];
        sm2  = x.stamp[7][STAMP_BITS-1:0] - x.stamp[6][STAMP_BITS-1:0];
        den  = DEN_W'(big1) + DEN_W'(big2) + DEN_W'(sm1) + DEN_W'(sm2);
        if (!x.ranging)
        begin
            r.tof = '0;
            r.status = ST_NOT_RANGING;
            return r;
        end
        if (den == 0)
        begin
            r.tof = '0;
            r.status = ST_ZERO_DEN;
            return r;
        end
        pa = PROD_W'(big1) * PROD_W'(big2);
        pb = PROD_W'(sm1) * PROD_W'(sm2);
        neg = pb > pa;
        diff = neg ? pb - pa : pa - pb;
        quo = (NUM_W'(diff) << FRACTION_BITS) / NUM_W'(den);
        lim = neg ? OUT_W'(1) << (OUT_W - 1) : (OUT_W'(1) << (OUT_W - 1)) - 1;
        if (quo > NUM_W'(lim))
        begin
            r.status = ST_SATURATED;
            quo = NUM_W'(lim);
        end
        else
            r.status = ST_OK;
        r.tof = neg ? -quo[OUT_W-1:0] : quo[OUT_W-1:0];
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] rand_stamp();
        return {8'($urandom_range(255, 0)), $urandom()};
    endfunction

    function automatic exchange_t make_exchange(logic [TIME_W-1:0] base [4],
                                                logic [TIME_W-1:0] span [4], logic rng);
        exchange_t x;
        for (int i = 0; i < 4; i++)
        begin
            x.stamp[2*i]   = base[i];
            x.stamp[2*i+1] = base[i] + span[i];
        end
        x.ranging = rng;
        x.known = 1'b0;
        x.tof = '0;
        x.status = ST_OK;
        return x;
    endfunction

    // Random exchange: mostly long round trips, slightly shorter replies; random wrap point.
    function automatic exchange_t random_exchange();
        logic [TIME_W-1:0] base [4];
        logic [TIME_W-1:0] span [4];
        int unsigned kind;
        kind = $urandom_range(9, 0);
        for (int i = 0; i < 4; i++)
        begin
            base[i] = rand_stamp();
            span[i] = rand_stamp();
        end
        if (kind < 7)
        begin
            span[0] = TIME_W'($urandom_range(32'hFFFFF, 0)) << $urandom_range(18, 0);
            span[2] = TIME_W'($urandom_range(32'hFFFFF, 0)) << $urandom_range(18, 0);
            span[1] = span[0] - TIME_W'($urandom_range(4000, 0));
            span[3] = span[2] - TIME_W'($urandom_range(4000, 0));
        end
        else if (kind == 7)
        begin
            for (int i = 0; i < 4; i++)
                span[i] = TIME_W'($urandom_range(3, 0));
        end
        return make_exchange(base, span, $urandom_range(15, 0) != 0);
    endfunction

    task automatic add_row(logic [TIME_W-1:0] s0, logic [TIME_W-1:0] s1,
                           logic [TIME_W-1:0] s2, logic [TIME_W-1:0] s3,
                           logic rng, logic known, logic signed [OUT_W-1:0] tof,
                           status_t st);
        logic [TIME_W-1:0] base [4];
        logic [TIME_W-1:0] span [4];
        exchange_t x;
        base = '{40'h12_3456_789A, 40'hFF_FFFF_FFF0, 40'h0, 40'h80_0000_0000};
        span = '{s0, s1, s2, s3};
        x = make_exchange(base, span, rng);
        x.known = known;
        x.tof = tof;
        x.status = st;
        directed.push_back(x);
    endtask

    // Valid drops only when a gap is drawn, so back-to-back items keep it high.
    task automatic send_exchange(exchange_t x);
        int gap;
        ranging_result_t r;
        gap = $urandom_range(3, 0);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        first_request_time      <= x.stamp[0];
        first_response_time     <= x.stamp[1];
        first_reception_time    <= x.stamp[2];
        first_transmission_time <= x.stamp[3];
        final_request_time      <= x.stamp[4];
        final_response_time     <= x.stamp[5];
        final_reception_time    <= x.stamp[6];
        final_transmission_time <= x.stamp[7];
        code_is_ranging         <= x.ranging;
        in_valid                <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = flight_of(x);
        if (x.known)
        begin
            r.tof = x.tof;
            r.status = x.status;
        end
        pending_results.push_back(r);
    endtask

    // Receiver: random wait per item, plus two long holds while the sender keeps going.
    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (150) @(posedge clk);
                long_hold = 1'b0;
            end
            hold = stim_done ? 0 : $urandom_range(3, 0);
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        ranging_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: flight_time %0d", flight_time);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (flight_time !== e.tof)
                begin
                    $error("flight_time expected %0d actual %0d", e.tof, flight_time);
                    error_count++;
                end
                if (result_status !== e.status)
                begin
                    $error("result_status expected %0d actual %0d", e.status, result_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [TIME_W-1:0] ones;
        ones = '1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        code_is_ranging = 1'b0;
        first_request_time = '0;
        first_response_time = '0;
        first_reception_time = '0;
        first_transmission_time = '0;
        final_request_time = '0;
        final_response_time = '0;
        final_reception_time = '0;
        final_transmission_time = '0;
        error_count = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        long_hold = 1'b0;

        // Spans in order: R1, r1, R2, r2.
        add_row(0, 0, 0, 0, 1'b1, 1'b1, 0, ST_ZERO_DEN);
        add_row(ones, ones, ones, ones, 1'b0, 1'b1, 0, ST_NOT_RANGING);
        add_row(0, 0, 0, 0, 1'b0, 1'b1, 0, ST_NOT_RANGING);
        add_row(100, 0, 0, 0, 1'b1, 1'b1, 0, ST_OK);
        add_row(2, 0, 2, 0, 1'b1, 1'b1, 256, ST_OK);
        add_row(0, 2, 0, 2, 1'b1, 1'b1, -256, ST_OK);
        add_row(5, 5, 5, 5, 1'b1, 1'b1, 0, ST_OK);
        add_row(ones, 0, ones, 0, 1'b1, 1'b0, 0, ST_OK);
        add_row(0, ones, 0, ones, 1'b1, 1'b0, 0, ST_OK);
        add_row(ones, 1, ones, 1, 1'b1, 1'b0, 0, ST_OK);
        add_row(1, ones, 1, ones, 1'b1, 1'b0, 0, ST_OK);
        add_row(ones, ones, ones, ones, 1'b1, 1'b0, 0, ST_OK);
        add_row(1, 0, 0, 0, 1'b1, 1'b0, 0, ST_OK);
        add_row(3, 1, 7, 2, 1'b1, 1'b0, 0, ST_OK);
        add_row(40'h55_5555_5555, 40'hAA_AAAA_AAAA, 40'h55_5555_5555, 40'h1, 1'b1,
                1'b0, 0, ST_OK);
        add_row(40'h1_0000_0000, 40'hFFFF_FF00, 40'h2_0000_0000, 40'h1_FFFF_FE00, 1'b1,
                1'b0, 0, ST_OK);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_exchange(directed[i]);

        long_hold = 1'b1;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 300)
                long_hold = 1'b1;
            send_exchange(random_exchange());
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/dtt_pkg.sv
src/dtt_front.sv
src/dtt_fifo.sv
src/dtt_back.sv
src/ds_twr_time_of_flight.sv
tb/ds_twr_time_of_flight_test.sv
